// ===== src/brl_pkg.sv =====
// shared types, constants and helpers for the line rasterizer
// used by brl_front, brl_job_queue, brl_walker and the top level
package brl_pkg;

    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 32;
    localparam int TILE_SIZE   = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // error term spans -dmaj .. 3*dmaj, plus sign
    localparam int ERR_W       = COORD_W + 3;

    localparam logic [COORD_W:0]   TILE_LIM = (COORD_W + 1)'(TILE_SIZE);
    localparam logic [COORD_W-1:0] TILE_MAX = COORD_W'(TILE_SIZE - 1);

    localparam logic [COLOR_W-1:0] DRAW_COLOR_RESET = '1;

    // one line after setup, ready to walk
    typedef struct packed {
        logic               steep;
        logic               minor_up;
        logic [COORD_W-1:0] start_major;
        logic [COORD_W-1:0] start_minor;
        logic [COORD_W-1:0] end_major;
        logic [COORD_W-1:0] dmaj;
        logic [COORD_W:0]   step2;
    } t_line_job;

    // coordinates at or past the tile edge saturate to the last column
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [COORD_W-1:0] r;
        r = v;
        if ({1'b0, v} >= TILE_LIM) begin
            r = TILE_MAX;
        end
        return r;
    endfunction

endpackage

// ===== src/brl_front.sv =====
// line setup: clamps endpoints, picks the major axis and orders the walk
// depends on brl_pkg
module brl_front (
    input  logic [brl_pkg::COORD_W-1:0] i_x_start,
    input  logic [brl_pkg::COORD_W-1:0] i_y_start,
    input  logic [brl_pkg::COORD_W-1:0] i_x_end,
    input  logic [brl_pkg::COORD_W-1:0] i_y_end,
    output brl_pkg::t_line_job          o_job
);
    import brl_pkg::*;

    logic [COORD_W-1:0] ax, ay, bx, by;
    logic [COORD_W:0]   dx, dy, dmin_s;
    logic [COORD_W-1:0] adx, ady, admin;
    logic               steep;
    logic [COORD_W-1:0] p_maj, p_min, q_maj, q_min;
    logic [COORD_W-1:0] s_maj, s_min, e_maj, e_min;

    // clamp and measure both axes
    always_comb begin
        ax  = clamp_coord(i_x_start);
        ay  = clamp_coord(i_y_start);
        bx  = clamp_coord(i_x_end);
        by  = clamp_coord(i_y_end);
        dx  = {1'b0, bx} - {1'b0, ax};
        dy  = {1'b0, by} - {1'b0, ay};
        adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    end

    // steep lines walk along y; ties stay on x
    always_comb begin
        steep = (adx < ady);
        p_maj = steep ? ay : ax;
        p_min = steep ? ax : ay;
        q_maj = steep ? by : bx;
        q_min = steep ? bx : by;
    end

    // order endpoints for increasing major coordinate
    always_comb begin
        if (q_maj < p_maj) begin
            s_maj = q_maj;
            s_min = q_min;
            e_maj = p_maj;
            e_min = p_min;
        end else begin
            s_maj = p_maj;
            s_min = p_min;
            e_maj = q_maj;
            e_min = q_min;
        end
        dmin_s = {1'b0, e_min} - {1'b0, s_min};
        admin  = dmin_s[COORD_W] ? COORD_W'(-dmin_s) : dmin_s[COORD_W-1:0];
    end

    // pack the walk setup
    always_comb begin
        o_job.steep       = steep;
        o_job.minor_up    = (e_min > s_min);
        o_job.start_major = s_maj;
        o_job.start_minor = s_min;
        o_job.end_major   = e_maj;
        o_job.dmaj        = e_maj - s_maj;
        o_job.step2       = {admin, 1'b0};
    end

endmodule

// ===== src/brl_job_queue.sv =====
// short fifo of set-up lines between the front and the walker
// depends on brl_pkg
module brl_job_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  brl_pkg::t_line_job  i_job,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output brl_pkg::t_line_job  o_job
);
    import brl_pkg::*;

    t_line_job          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]  r_count,  n_count;

    // pointer wrap
    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    // next pointers and fill level
    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== src/brl_walker.sv =====
// bresenham walk: one pixel per cycle into an output register while the output is not stalled
// depends on brl_pkg
module brl_walker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    input  brl_pkg::t_line_job          i_job,
    output logic                        o_job_pop,
    input  logic [brl_pkg::COLOR_W-1:0] i_color,
    output logic                        o_pixel_valid,
    input  logic                        i_pixel_stall,
    output logic [brl_pkg::COORD_W-1:0] o_pixel_x,
    output logic [brl_pkg::COORD_W-1:0] o_pixel_y,
    output logic [brl_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                        o_last_pixel
);
    import brl_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state                    r_state;
    logic                      r_steep;
    logic                      r_minor_up;
    logic [COORD_W-1:0]        r_major;
    logic [COORD_W-1:0]        r_minor;
    logic [COORD_W-1:0]        r_end;
    logic [COORD_W-1:0]        r_dmaj;
    logic [COORD_W:0]          r_step2;
    logic signed [ERR_W-1:0]   r_err;
    logic                      r_out_valid;
    logic [COORD_W-1:0]        r_out_x;
    logic [COORD_W-1:0]        r_out_y;
    logic [COLOR_W-1:0]        r_out_color;
    logic                      r_out_last;

    logic                      out_free;
    logic                      emit;
    logic                      at_end;
    logic signed [ERR_W-1:0]   err_sum;
    logic                      minor_step;
    logic signed [ERR_W-1:0]   n_err;
    logic [COORD_W-1:0]        n_minor;

    assign out_free  = !r_out_valid || !i_pixel_stall;
    assign emit      = (r_state == ST_WALK) && out_free;
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign at_end    = (r_major == r_end);

    // error update for the next pixel
    always_comb begin
        err_sum    = r_err + $signed({2'b00, r_step2});
        minor_step = (err_sum > $signed({3'b000, r_dmaj}));
        n_err      = minor_step ? err_sum - $signed({2'b00, r_dmaj, 1'b0}) : err_sum;
        n_minor    = r_minor_up ? r_minor + 1'b1 : r_minor - 1'b1;
    end

    // walk sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= emit;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (emit && at_end) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath: load a job, then step once per emitted pixel
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_steep    <= i_job.steep;
            r_minor_up <= i_job.minor_up;
            r_major    <= i_job.start_major;
            r_minor    <= i_job.start_minor;
            r_end      <= i_job.end_major;
            r_dmaj     <= i_job.dmaj;
            r_step2    <= i_job.step2;
            r_err      <= '0;
        end else if (emit) begin
            r_major <= r_major + 1'b1;
            r_err   <= n_err;
            if (minor_step) begin
                r_minor <= n_minor;
            end
        end
        if (emit) begin
            r_out_x     <= r_steep ? r_minor : r_major;
            r_out_y     <= r_steep ? r_major : r_minor;
            r_out_color <= i_color;
            r_out_last  <= at_end;
        end
    end

    assign o_pixel_valid = r_out_valid;
    assign o_pixel_x     = r_out_x;
    assign o_pixel_y     = r_out_y;
    assign o_pixel_color = r_out_color;
    assign o_last_pixel  = r_out_last;

endmodule

// ===== src/bresenham_line_rasterizer_core.sv =====
// top level of the bresenham line rasterizer: setup, job queue, walker
// depends on brl_pkg, brl_front, brl_job_queue, brl_walker
//
// channel   direction  handshake                        payload
// line      in         i_line_valid / o_line_stall      x_start y_start x_end y_end
// pixel     out        o_pixel_valid / i_pixel_stall    pixel_x pixel_y pixel_color last_pixel
// cfg       in         i_cfg_valid / o_cfg_ready        draw_color
//
// a line of n pixels (n = major distance + 1, 1..64) is walked by first loading the job from
// the queue, then one pixel per cycle while the output is not stalled.
// setup is done on the way into the two-entry job queue, so lines are taken while
// the walker is busy until the queue fills; o_line_stall is the queue-full flag.
// i_pixel_stall holds a waiting pixel in the output register and freezes the walk.
// synchronous active-low reset empties the queue, idles the walker and sets
// draw_color to all ones.
module bresenham_line_rasterizer_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_line_valid,
    output logic                        o_line_stall,
    input  logic [brl_pkg::COORD_W-1:0] i_x_start,
    input  logic [brl_pkg::COORD_W-1:0] i_y_start,
    input  logic [brl_pkg::COORD_W-1:0] i_x_end,
    input  logic [brl_pkg::COORD_W-1:0] i_y_end,
    output logic                        o_pixel_valid,
    input  logic                        i_pixel_stall,
    output logic [brl_pkg::COORD_W-1:0] o_pixel_x,
    output logic [brl_pkg::COORD_W-1:0] o_pixel_y,
    output logic [brl_pkg::COLOR_W-1:0] o_pixel_color,
    output logic                        o_last_pixel,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [brl_pkg::COLOR_W-1:0] i_cfg_draw_color
);
    import brl_pkg::*;

    logic [COLOR_W-1:0] r_draw_color;
    t_line_job          setup_job;
    t_line_job          queue_job;
    logic               queue_full;
    logic               queue_valid;
    logic               queue_pop;
    logic               line_xfer;

    assign o_cfg_ready  = 1'b1;
    assign o_line_stall = queue_full;
    assign line_xfer    = i_line_valid && !queue_full;

    // draw color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color <= DRAW_COLOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_draw_color <= i_cfg_draw_color;
        end
    end

    brl_front u_front (
        .i_x_start (i_x_start),
        .i_y_start (i_y_start),
        .i_x_end   (i_x_end),
        .i_y_end   (i_y_end),
        .o_job     (setup_job)
    );

    brl_job_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (line_xfer),
        .i_job   (setup_job),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_job   (queue_job)
    );

    brl_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (queue_valid),
        .i_job         (queue_job),
        .o_job_pop     (queue_pop),
        .i_color       (r_draw_color),
        .o_pixel_valid (o_pixel_valid),
        .i_pixel_stall (i_pixel_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_pixel  (o_last_pixel)
    );

    // an accepted line is waiting in the queue on the next cycle
    a_line_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_xfer |=> queue_valid)
        else $error("accepted line missing from job queue");

    // a pixel that is not the last one is followed at once by the next
    a_walk_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && !i_pixel_stall && !o_last_pixel) |=> o_pixel_valid)
        else $error("walk stopped before last pixel");

    // the walker only pops when the queue holds a job
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_pop |-> queue_valid)
        else $error("pop from empty job queue");

endmodule

// ===== tb/sv/bresenham_line_rasterizer_core_test.sv =====
// self-checking testbench for bresenham_line_rasterizer_core: line segments in, pixels out
// depends on brl_pkg and the rasterizer rtl; pixels are checked against a line tracer kept here
module bresenham_line_rasterizer_core_test;
    import brl_pkg::*;

    typedef struct {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } t_seg;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } t_pixel;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    always #4 clk = ~clk;

    // block inputs, all known from time zero
    logic               line_valid = 1'b0;
    logic [COORD_W-1:0] x_start = '0;
    logic [COORD_W-1:0] y_start = '0;
    logic [COORD_W-1:0] x_end = '0;
    logic [COORD_W-1:0] y_end = '0;
    logic               pixel_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [COLOR_W-1:0] cfg_color = '0;

    // block outputs
    logic               line_stall;
    logic               pixel_valid;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
    logic               cfg_ready;

    // shared testbench state
    t_seg               seg_q[$];
    t_pixel             pixel_expect[$];
    logic [COLOR_W-1:0] color_now = DRAW_COLOR_RESET;
    bit                 send_gaps = 1'b1;
    bit                 stall_gaps = 1'b1;
    int                 hold_req = 0;
    int                 hold_seen = 0;
    int                 hold_left = 0;
    int                 segs_sent = 0;
    int                 pixels_seen = 0;
    int                 mismatches = 0;

    bresenham_line_rasterizer_core u_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_line_valid     (line_valid),
        .o_line_stall     (line_stall),
        .i_x_start        (x_start),
        .i_y_start        (y_start),
        .i_x_end          (x_end),
        .i_y_end          (y_end),
        .o_pixel_valid    (pixel_valid),
        .i_pixel_stall    (pixel_stall),
        .o_pixel_x        (pixel_x),
        .o_pixel_y        (pixel_y),
        .o_pixel_color    (pixel_color),
        .o_last_pixel     (last_pixel),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_draw_color (cfg_color)
    );

    // one line per mismatch
    task report_mismatch(input string msg);
        $display("ERROR t=%0t: %s", $time, msg);
        mismatches++;
    endtask

    // walk the segment and queue every pixel it visits
    task automatic trace_line(input t_seg s);
        int     ax, ay, bx, by, t, dmaj, dmin, step2, err, minor, inc, major;
        bit     steep;
        t_pixel p;
        // tile is the full 6-bit range, so no coordinate saturates
        ax = int'(s.x_start);
        ay = int'(s.y_start);
        bx = int'(s.x_end);
        by = int'(s.y_end);
        steep = ((bx > ax ? bx - ax : ax - bx) < (by > ay ? by - ay : ay - by));
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        // walk in increasing major order
        if (bx < ax) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dmaj = bx - ax;
        dmin = by - ay;
        step2 = (dmin < 0 ? -dmin : dmin) * 2;
        inc = (by > ay) ? 1 : -1;
        err = 0;
        minor = ay;
        for (major = ax; major <= bx; major++) begin
            p.x = COORD_W'(steep ? minor : major);
            p.y = COORD_W'(steep ? major : minor);
            p.color = color_now;
            p.last = (major == bx);
            pixel_expect.push_back(p);
            err += step2;
            if (err > dmaj) begin
                minor += inc;
                err -= dmaj * 2;
            end
        end
    endtask

    // line driver: holds the front segment until transfer, then offers the next
    always @(posedge clk) begin : line_driver
        bit offer;
        if (!rst_n) begin
            line_valid <= 1'b0;
        end else begin
            offer = line_valid;
            if (line_valid && !line_stall) begin
                trace_line(seg_q.pop_front());
                segs_sent++;
                offer = 1'b0;
            end
            if (!offer && seg_q.size() != 0) begin
                offer = !(send_gaps && $urandom_range(99) < 35);
            end
            line_valid <= offer;
            if (offer) begin
                x_start <= seg_q[0].x_start;
                y_start <= seg_q[0].y_start;
                x_end   <= seg_q[0].x_end;
                y_end   <= seg_q[0].y_end;
            end
        end
    end

    // long output hold-off, counted here in cycles
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
        end
    end

    // pixel monitor: compare each transfer with the oldest expected pixel
    always @(posedge clk) begin : pixel_monitor
        t_pixel e;
        if (rst_n && pixel_valid && !pixel_stall) begin
            pixels_seen++;
            if (pixel_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
            end else begin
                e = pixel_expect.pop_front();
                if (pixel_x !== e.x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d", pixel_x, e.x));
                if (pixel_y !== e.y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d", pixel_y, e.y));
                if (pixel_color !== e.color)
                    report_mismatch($sformatf("pixel_color %h, expected %h",
                                              pixel_color, e.color));
                if (last_pixel !== e.last)
                    report_mismatch($sformatf("last_pixel %b, expected %b at (%0d,%0d)",
                                              last_pixel, e.last, e.x, e.y));
            end
        end
        pixel_stall <= (hold_left != 0) || (stall_gaps && $urandom_range(99) < 35);
    end

    function automatic t_seg make_seg(input int xa, input int ya, input int xb, input int yb);
        t_seg s;
        s.x_start = COORD_W'(xa);
        s.y_start = COORD_W'(ya);
        s.x_end   = COORD_W'(xb);
        s.y_end   = COORD_W'(yb);
        return s;
    endfunction

    // free segments half the time, plus short, axis-aligned and single-point ones
    function automatic t_seg rand_seg();
        t_seg s;
        int   kind;
        kind = $urandom_range(9);
        s = make_seg($urandom_range(63), $urandom_range(63),
                     $urandom_range(63), $urandom_range(63));
        case (kind)
            5, 6: begin
                s.x_end = s.x_start + COORD_W'($urandom_range(6)) - COORD_W'(3);
                s.y_end = s.y_start + COORD_W'($urandom_range(6)) - COORD_W'(3);
            end
            7: s.y_end = s.y_start;
            8: s.x_end = s.x_start;
            9: begin
                s.x_end = s.x_start;
                s.y_end = s.y_start;
            end
            default: ;
        endcase
        return s;
    endfunction

    // color register write, only while nothing is in flight
    task write_color(input logic [COLOR_W-1:0] c);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_color <= c;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        color_now = c;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task wait_drained();
        do @(negedge clk); while (seg_q.size() != 0 || pixel_expect.size() != 0);
    endtask

    task queue_random(input int n);
        repeat (n) seg_q.push_back(rand_seg());
    endtask

    // stimulus sequence
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed segments at the reset color
        seg_q.push_back(make_seg(0, 0, 0, 0));
        seg_q.push_back(make_seg(63, 63, 63, 63));
        seg_q.push_back(make_seg(0, 0, 63, 0));
        seg_q.push_back(make_seg(63, 63, 0, 63));
        seg_q.push_back(make_seg(0, 0, 0, 63));
        seg_q.push_back(make_seg(63, 63, 63, 0));
        seg_q.push_back(make_seg(0, 0, 63, 63));
        seg_q.push_back(make_seg(0, 63, 63, 0));
        seg_q.push_back(make_seg(63, 0, 0, 63));
        seg_q.push_back(make_seg(10, 60, 20, 5));
        seg_q.push_back(make_seg(0, 40, 63, 20));
        seg_q.push_back(make_seg(40, 10, 10, 40));
        seg_q.push_back(make_seg(50, 3, 2, 30));
        seg_q.push_back(make_seg(5, 63, 0, 0));
        seg_q.push_back(make_seg(3, 4, 4, 6));
        seg_q.push_back(make_seg(7, 7, 8, 7));
        seg_q.push_back(make_seg(21, 42, 42, 21));
        seg_q.push_back(make_seg(62, 1, 61, 63));
        wait_drained();

        // random segments, black
        write_color('0);
        queue_random(100);
        wait_drained();

        // output held off while the sender keeps offering
        send_gaps = 1'b0;
        hold_req++;
        queue_random(20);
        wait_drained();

        // stretch with no idling on either side
        write_color(COLOR_W'($urandom));
        stall_gaps = 1'b0;
        queue_random(100);
        wait_drained();

        // back to gaps, all-ones color written explicitly
        write_color('1);
        send_gaps = 1'b1;
        stall_gaps = 1'b1;
        queue_random(100);
        wait_drained();

        // let any stray pixel show up
        repeat (100) @(negedge clk);
        $display("%0d segments, %0d pixels: axis-aligned, diagonal, reversed, single-point",
                 segs_sent, pixels_seen);
        $display("colors black, white and random; output hold-off and back-to-back stretch");
        if (mismatches == 0 && pixel_expect.size() == 0) begin
            $display("bresenham_line_rasterizer_core: match");
        end else begin
            $display("bresenham_line_rasterizer_core: mismatch");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("timeout with %0d pixels still expected", pixel_expect.size());
        $display("bresenham_line_rasterizer_core: mismatch");
        $finish;
    end

endmodule
